// ===== rtl/lss_pkg.sv =====
// Shared definitions for the LIFO stack with search: widths, request kinds
// and status codes used by the stack unit and its port checker.
// No dependencies.
package lss_pkg;

  // Default number of stack entries.
  localparam int LSS_DEPTH = 64;

  // Field widths of the request and result items.
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int FIELD_W = 7;
  localparam int STAT_W  = 3;

  // Result tdata layout: word, position, removed, depth_now, is_empty, padded.
  localparam int RES_BITS = DATA_W + 3 * FIELD_W + 1;
  localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_PUSH   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd4;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

endpackage

// ===== rtl/lifo_stack_with_search_unit.sv =====
// LIFO stack of signed 32-bit words with push, pop, peek, search and clear.
// Holds the entry memory, the fill count and the request sequencer.
// Depends on lss_pkg.
//
// Usage: requests arrive on the s_axis channel, one transfer per request,
// with the request kind in tuser and the operand word in tdata. Every request
// produces exactly one result transfer on the m_axis channel, carrying the
// top word (pop, peek), the search hit position, the count removed by clear,
// the count afterwards, an empty flag, and a status code in tuser.
// Timing: the entries sit in a single-port memory with registered read data.
// Push, clear and unused kinds go from accept to the result state and then
// back to idle; pop and peek pass through a read state first (one memory
// read). Search reads one entry per cycle from the top and compares it
// against the key in a single shared comparator, and stops at the first
// hit. s_axis_tready is high only while the sequencer is idle.
// The result sits in an output register, so the next request is accepted
// while a result waits; if the receiver stalls, the sequencer holds its next
// result until the output register is free.
// Reset (rst, synchronous) empties the stack and drops m_axis_tvalid; the
// memory contents are not cleared, since only written entries are ever read.
module lifo_stack_with_search_unit
  import lss_pkg::*;
#(
  parameter int DEPTH = LSS_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  // Requests. tdata: value[31:0]. tuser: kind[2:0].
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [DATA_W-1:0]  s_axis_tdata,
  input  logic [KIND_W-1:0]  s_axis_tuser,
  // Results. tdata: word[31:0], position[38:32], removed[45:39],
  // depth_now[52:46], is_empty[53], zero[55:54]. tuser: status[2:0].
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [RES_W-1:0]   m_axis_tdata,
  output logic [STAT_W-1:0]  m_axis_tuser
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SCAN,
    S_RESULT
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [DATA_W-1:0]   key;
  logic [AW-1:0]       scan_addr;
  logic [CW-1:0]       cmp_pos;
  logic [DATA_W-1:0]   res_word;
  logic [CW-1:0]       res_pos;
  logic [CW-1:0]       res_removed;
  logic [STAT_W-1:0]   res_status;

  logic [DATA_W-1:0]   mem [DEPTH];
  logic [DATA_W-1:0]   rd_data;
  logic                mem_we;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       top_addr;

  logic                in_xfer;
  logic                out_free;
  logic                full;
  logic                hit;
  logic                last_cmp;
  logic [CW+FIELD_W-1:0] pos_ext;
  logic [CW+FIELD_W-1:0] rem_ext;
  logic [CW+FIELD_W-1:0] cnt_ext;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign full     = (count == CW'(DEPTH));
  assign top_addr = count[AW-1:0] - AW'(1);
  assign hit      = (rd_data == key);
  assign last_cmp = (cmp_pos == count);

  // Result counts are reported as their low seven bits.
  assign pos_ext = {{FIELD_W{1'b0}}, res_pos};
  assign rem_ext = {{FIELD_W{1'b0}}, res_removed};
  assign cnt_ext = {{FIELD_W{1'b0}}, count};

  // Memory port control: push writes on accept, pop/peek/search read the top,
  // and the scan keeps one read in flight ahead of the comparator.
  always_comb begin
    mem_we  = 1'b0;
    rd_en   = 1'b0;
    rd_addr = top_addr;
    if (in_xfer) begin
      case (s_axis_tuser)
        KIND_PUSH: mem_we = !full;
        KIND_POP, KIND_PEEK, KIND_SEARCH: rd_en = (count != '0);
        default: ;
      endcase
    end else if (state == S_SCAN) begin
      rd_en   = !hit && !last_cmp;
      rd_addr = scan_addr;
    end
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count[AW-1:0]] <= s_axis_tdata;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Request sequencer, fill count and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // A taken result frees the output register unless a new one loads now.
      if (m_axis_tready && state != S_RESULT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            key         <= s_axis_tdata;
            res_word    <= '0;
            res_pos     <= '0;
            res_removed <= '0;
            res_status  <= STAT_OK;
            scan_addr   <= top_addr - AW'(1);
            cmp_pos     <= CW'(1);
            state       <= S_RESULT;
            case (s_axis_tuser)
              KIND_PUSH: begin
                if (full) begin
                  res_status <= STAT_OVERFLOW;
                end else begin
                  count <= count + CW'(1);
                end
              end
              KIND_POP, KIND_PEEK: begin
                if (count == '0) begin
                  res_status <= STAT_UNDERFLOW;
                end else begin
                  state <= S_READ;
                  if (s_axis_tuser == KIND_POP) begin
                    count <= count - CW'(1);
                  end
                end
              end
              KIND_SEARCH: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  state <= S_SCAN;
                end
              end
              KIND_CLEAR: begin
                if (count == '0) begin
                  res_status <= STAT_EMPTY;
                end else begin
                  res_removed <= count;
                  count       <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          res_word <= rd_data;
          state    <= S_RESULT;
        end
        S_SCAN: begin
          // Compare the entry read last cycle; positions count from the top.
          if (hit) begin
            res_pos <= cmp_pos;
            state   <= S_RESULT;
          end else if (last_cmp) begin
            res_status <= STAT_NOT_FOUND;
            state      <= S_RESULT;
          end else begin
            scan_addr <= scan_addr - AW'(1);
            cmp_pos   <= cmp_pos + CW'(1);
          end
        end
        S_RESULT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= RES_W'({(count == '0), cnt_ext[FIELD_W-1:0],
                                     rem_ext[FIELD_W-1:0], pos_ext[FIELD_W-1:0],
                                     res_word});
            m_axis_tuser  <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/lss_checker.sv =====
// Port-level checks for the LIFO stack with search, and the bind that
// attaches them to lifo_stack_with_search_unit.
// Depends on lss_pkg.
module lss_checker
  import lss_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_axis_tvalid,
  input logic               s_axis_tready,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [RES_W-1:0]   m_axis_tdata,
  input logic [STAT_W-1:0]  m_axis_tuser
);

  // Reset leaves no result pending.
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // Each request keeps the block busy for at least the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted on back-to-back cycles");

  // Underflow never returns a word.
  a_underflow_word: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STAT_UNDERFLOW |-> m_axis_tdata[31:0] == '0)
    else $error("underflow result carries a word");

  // An empty status always comes with the empty flag set.
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == STAT_EMPTY |-> m_axis_tdata[53])
    else $error("empty status without empty flag");

endmodule

bind lifo_stack_with_search_unit lss_checker u_lss_checker (.*);

// ===== bench/lifo_stack_with_search_unit_test.sv =====
// Self-checking testbench for the LIFO stack with search unit.
// It predicts each result in a behavioral copy of the stack and checks it.
// Depends on lss_pkg and lifo_stack_with_search_unit.
module lifo_stack_with_search_unit_test;
  import lss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Highest request code; the codes above KIND_CLEAR are unused by the block.
  localparam logic [KIND_W-1:0] KIND_TOP_CODE = 3'd7;
  localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [DATA_W-1:0] WORD_MAX = 32'h7FFF_FFFF;

  // Result tdata bit positions, lowest field first.
  localparam int POS_LSB   = DATA_W;
  localparam int REM_LSB   = DATA_W + FIELD_W;
  localparam int CNT_LSB   = DATA_W + 2 * FIELD_W;
  localparam int EMPTY_BIT = DATA_W + 3 * FIELD_W;

  typedef struct packed {
    logic [DATA_W-1:0]  word;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] removed;
    logic [FIELD_W-1:0] depth_now;
    logic               is_empty;
    logic [STAT_W-1:0]  status;
  } stack_reply_t;

  logic               clk;
  logic               rst;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [DATA_W-1:0]  s_axis_tdata;
  logic [KIND_W-1:0]  s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [RES_W-1:0]   m_axis_tdata;
  logic [STAT_W-1:0]  m_axis_tuser;

  // Predicted stack contents and the replies still owed by the block.
  logic [DATA_W-1:0]  stack_words [LSS_DEPTH];
  int                 stack_fill;
  stack_reply_t       replies_due [$];
  int                 bad_replies;

  // Traffic shaping shared with the reply checker.
  int                 tx_idle_pct;
  int                 rx_stall_pct;
  int                 rx_hold_left;

  lifo_stack_with_search_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Applies one request to the predicted stack and returns the reply it owes.
  function automatic stack_reply_t advance_stack(logic [KIND_W-1:0] kind,
                                                 logic [DATA_W-1:0] value);
    stack_reply_t reply;
    int           i;
    reply = '0;
    reply.status = STAT_OK;
    case (kind)
      KIND_PUSH: begin
        if (stack_fill >= LSS_DEPTH) begin
          reply.status = STAT_OVERFLOW;
        end else begin
          stack_words[stack_fill] = value;
          stack_fill++;
        end
      end
      KIND_POP: begin
        if (stack_fill == 0) begin
          reply.status = STAT_UNDERFLOW;
        end else begin
          stack_fill--;
          reply.word = stack_words[stack_fill];
        end
      end
      KIND_PEEK: begin
        if (stack_fill == 0) begin
          reply.status = STAT_UNDERFLOW;
        end else begin
          reply.word = stack_words[stack_fill - 1];
        end
      end
      KIND_SEARCH: begin
        if (stack_fill == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          // Scan from the top; the first hit wins.
          reply.status = STAT_NOT_FOUND;
          for (i = 0; i < stack_fill && reply.status != STAT_OK; i++) begin
            if (stack_words[stack_fill - 1 - i] == value) begin
              reply.position = FIELD_W'(i + 1);
              reply.status = STAT_OK;
            end
          end
        end
      end
      KIND_CLEAR: begin
        if (stack_fill == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          reply.removed = FIELD_W'(stack_fill);
          stack_fill = 0;
        end
      end
      default: begin
        // Unused codes leave the stack alone.
      end
    endcase
    reply.depth_now = FIELD_W'(stack_fill);
    reply.is_empty = (stack_fill == 0);
    return reply;
  endfunction

  // Small values often enough that duplicates occur, plus extremes and full words.
  function automatic logic [DATA_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return DATA_W'($urandom_range(15)) - DATA_W'(8);
    if (r < 50) begin
      case ($urandom_range(3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom;
  endfunction

  // Sends one request after an optional idle gap and records its reply.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic [DATA_W-1:0] value);
    int gap;
    gap = 0;
    while (gap < 30 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= value;
    do @(posedge clk); while (!s_axis_tready);
    replies_due.push_back(advance_stack(kind, value));
  endtask

  // Stops offering requests until every owed reply has arrived.
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  // Compares one reply transfer against the oldest prediction.
  task automatic check_reply();
    stack_reply_t want;
    stack_reply_t got;
    got.word      = m_axis_tdata[DATA_W-1:0];
    got.position  = m_axis_tdata[POS_LSB +: FIELD_W];
    got.removed   = m_axis_tdata[REM_LSB +: FIELD_W];
    got.depth_now = m_axis_tdata[CNT_LSB +: FIELD_W];
    got.is_empty  = m_axis_tdata[EMPTY_BIT];
    got.status    = m_axis_tuser;
    if (replies_due.size() == 0) begin
      bad_replies++;
      if (bad_replies <= 10)
        $display("%0t: reply with nothing owed: word=%0d status=%0d", $realtime,
                 $signed(got.word), got.status);
    end else begin
      want = replies_due.pop_front();
      if (got !== want) begin
        bad_replies++;
        if (bad_replies <= 10) begin
          $display("%0t: reply mismatch", $realtime);
          $display("  expected word=%0d position=%0d removed=%0d depth=%0d empty=%0b status=%0d",
                   $signed(want.word), want.position, want.removed, want.depth_now,
                   want.is_empty, want.status);
          $display("  actual   word=%0d position=%0d removed=%0d depth=%0d empty=%0b status=%0d",
                   $signed(got.word), got.position, got.removed, got.depth_now,
                   got.is_empty, got.status);
        end
      end
    end
  endtask

  // Reply side: checks each transfer, then stalls at random or holds off.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) check_reply();
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Requests on an empty stack, including the unused codes.
  task automatic test_empty_stack();
    send_request(KIND_POP, pick_value());
    send_request(KIND_PEEK, pick_value());
    send_request(KIND_SEARCH, '0);
    send_request(KIND_CLEAR, pick_value());
    for (int k = KIND_CLEAR + 1; k <= KIND_TOP_CODE; k++)
      send_request(KIND_W'(k), $urandom);
    wait_for_drain();
  endtask

  // Every operation on a small stack with extreme and repeated words.
  task automatic test_basic_ops();
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PUSH, '1);
    send_request(KIND_PUSH, '0);
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PEEK, '0);
    send_request(KIND_SEARCH, WORD_MAX);
    send_request(KIND_SEARCH, WORD_MIN);
    send_request(KIND_SEARCH, 32'd12345);
    send_request(KIND_W'(KIND_TOP_CODE - 1), WORD_MAX);
    send_request(KIND_POP, '0);
    send_request(KIND_POP, '0);
    send_request(KIND_CLEAR, '0);
    send_request(KIND_SEARCH, WORD_MIN);
    wait_for_drain();
  endtask

  // Fills the store, pushes past full, searches the deepest entry, pops it dry.
  task automatic test_full_store();
    for (int i = 0; i < LSS_DEPTH; i++)
      send_request(KIND_PUSH, 32'h5A00_0000 | DATA_W'(i));
    send_request(KIND_PUSH, WORD_MAX);
    send_request(KIND_PUSH, WORD_MIN);
    send_request(KIND_PEEK, '0);
    send_request(KIND_SEARCH, 32'h5A00_0000);
    send_request(KIND_SEARCH, 32'h5A00_0000 | DATA_W'(LSS_DEPTH - 1));
    send_request(KIND_SEARCH, WORD_MAX);
    for (int i = 0; i <= LSS_DEPTH; i++)
      send_request(KIND_POP, '0);
    wait_for_drain();
  endtask

  // Random requests: pushes, pops, peeks, searches that often hit, clears and unused codes.
  task automatic test_random_traffic(input int count, input int tx_pct, input int rx_pct);
    int push_pct;
    int r;
    logic [DATA_W-1:0] key;
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    push_pct = 50;
    for (int n = 0; n < count; n++) begin
      // Change the push bias now and then so the fill level wanders end to end.
      if (n % 50 == 0) begin
        case ($urandom_range(2))
          0: push_pct = 25;
          1: push_pct = 50;
          default: push_pct = 80;
        endcase
      end
      if ($urandom_range(79) == 0) wait_for_drain();
      if ($urandom_range(99) < push_pct) begin
        send_request(KIND_PUSH, pick_value());
      end else begin
        r = $urandom_range(99);
        if (r < 30) begin
          send_request(KIND_POP, pick_value());
        end else if (r < 45) begin
          send_request(KIND_PEEK, pick_value());
        end else if (r < 88) begin
          if (stack_fill > 0 && $urandom_range(99) < 70)
            key = stack_words[$urandom_range(stack_fill - 1)];
          else
            key = pick_value();
          send_request(KIND_SEARCH, key);
        end else if (r < 93) begin
          send_request(KIND_CLEAR, pick_value());
        end else begin
          send_request(KIND_W'($urandom_range(KIND_TOP_CODE, KIND_CLEAR + 1)), $urandom);
        end
      end
    end
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold_left = 300;
    for (int i = 0; i < 20; i++) send_request(KIND_PUSH, pick_value());
    for (int i = 0; i < 10; i++) send_request(KIND_SEARCH, pick_value());
    wait_for_drain();
  endtask

  // Test sequence.
  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_PUSH;
    stack_fill    = 0;
    bad_replies   = 0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    rx_hold_left  = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_stack();
    test_basic_ops();
    test_full_store();
    test_backpressure();
    test_random_traffic(240, 0, 0);
    test_random_traffic(240, 65, 0);
    test_random_traffic(240, 0, 65);
    test_random_traffic(240, 38, 38);

    // Let a late or extra reply surface before the verdict.
    wait_for_drain();
    repeat (LSS_DEPTH + 8) @(posedge clk);
    if (bad_replies == 0 && replies_due.size() == 0) begin
      $display("** lifo_stack_with_search_unit: PASSED **");
    end else begin
      $display("** lifo_stack_with_search_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10ms;
    $display("** lifo_stack_with_search_unit: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/lss_pkg.sv
rtl/lifo_stack_with_search_unit.sv
rtl/lss_checker.sv
bench/lifo_stack_with_search_unit_test.sv
